[hdl/dsm_pkg.sv]
package dsm_pkg;

    localparam int STATE_COUNT_DEF   = 16;
    localparam int ALPHABET_SIZE_DEF = 256;

    localparam int STATE_W = 4;
    localparam int SYM_W   = 8;
    localparam int OP_W    = 2;
    localparam int CAUSE_W = 2;
    localparam int APB_W   = 32;
    localparam int PADDR_W = 3;

    // register index as decoded from paddr[2]
    localparam logic [0:0] REG_START_STATE = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_EDGE_WR = 2'd0,
        OP_TERM_WR = 2'd1,
        OP_FEED    = 2'd2,
        OP_EMPTY_Q = 2'd3
    } t_op;

    typedef enum logic [CAUSE_W-1:0] {
        CAUSE_NONE     = 2'd0,
        CAUSE_NO_EDGE  = 2'd1,
        CAUSE_NOT_TERM = 2'd2
    } t_cause;

    typedef struct packed {
        logic ok;
        logic [STATE_W-1:0] dest;
    } t_edge;

    typedef struct packed {
        logic wr;
        logic rd;
    } t_tbl_ctl;

    // state index bits used to address the table
    function automatic int tbl_state_bits(int sc);
        return $clog2(sc < (1 << STATE_W) ? sc : (1 << STATE_W));
    endfunction

    function automatic logic state_ok(logic [STATE_W-1:0] s, int sc);
        return int'(s) < sc;
    endfunction

    function automatic logic sym_ok(logic [SYM_W-1:0] s, int as);
        return int'(s) < as;
    endfunction

endpackage

[hdl/dfa_string_matcher_top.sv]
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+------------------------------------------------
// item in   | i_in_valid  | o_in_stall  | i_op i_state_index i_symbol i_next_state
//           |             |             | i_edge_valid i_terminal_flag i_last
// result    | o_out_valid | i_out_stall | o_accepted o_reject_cause
// config    | apb psel/penable/pwrite/pready, start_state at byte address 0
//
// one item per cycle while o_in_stall is low; a result reaches the ports through the stage 1
// register, loaded at its item's transaction edge, then the output register. the pace is set by
// the table's registered read: the edge read for one symbol picks the address of the next
// after reset the transition table is cleared one entry a cycle, 4096 entries at
// the default size (2^(state bits + symbol bits)); items stall during the sweep
// a blocked result holds only stage 1 and only when stage 1 also carries a result
module dfa_string_matcher_top
    import dsm_pkg::*;
#(
    parameter int STATE_COUNT   = STATE_COUNT_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // apb config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [STATE_W-1:0] i_state_index,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic [STATE_W-1:0] i_next_state,
    input  logic               i_edge_valid,
    input  logic               i_terminal_flag,
    input  logic               i_last,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic [CAUSE_W-1:0] o_reject_cause
);

    // table address: state bits then symbol bits
    localparam int ADDR_W = tbl_state_bits(STATE_COUNT) + $clog2(ALPHABET_SIZE);

    logic               cfg_wr;
    logic [STATE_W-1:0] start_state;
    logic               clr_busy;
    t_tbl_ctl           tbl_ctl;
    logic [ADDR_W-1:0]  tbl_addr;
    t_edge              tbl_wdata;
    t_edge              tbl_rdata;

    // register write on the access phase, no wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && paddr[2:2] == REG_START_STATE;

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == REG_START_STATE) begin
            prdata = {{(APB_W - STATE_W){1'b0}}, start_state};
        end
    end

    dsm_core #(
        .STATE_COUNT   (STATE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .ADDR_W        (ADDR_W)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_op            (i_op),
        .i_state_index   (i_state_index),
        .i_symbol        (i_symbol),
        .i_next_state    (i_next_state),
        .i_edge_valid    (i_edge_valid),
        .i_terminal_flag (i_terminal_flag),
        .i_last          (i_last),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_accepted      (o_accepted),
        .o_reject_cause  (o_reject_cause),
        .i_cfg_wr        (cfg_wr),
        .i_cfg_start     (pwdata[STATE_W-1:0]),
        .o_start_state   (start_state),
        .i_clr_busy      (clr_busy),
        .o_tbl_ctl       (tbl_ctl),
        .o_tbl_addr      (tbl_addr),
        .o_tbl_wdata     (tbl_wdata),
        .i_tbl_rdata     (tbl_rdata)
    );

    // transition table memory with its clearing sweep
    dsm_table #(
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (tbl_ctl),
        .i_addr     (tbl_addr),
        .i_wdata    (tbl_wdata),
        .o_rdata    (tbl_rdata),
        .o_clr_busy (clr_busy)
    );

endmodule

[hdl/dsm_table.sv]
module dsm_table
    import dsm_pkg::*;
#(
    parameter int ADDR_W = tbl_state_bits(STATE_COUNT_DEF) + $clog2(ALPHABET_SIZE_DEF)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tbl_ctl          i_ctl,
    input  logic [ADDR_W-1:0] i_addr,
    input  t_edge             i_wdata,
    output t_edge             o_rdata,
    output logic              o_clr_busy
);

    localparam int DEPTH = 1 << ADDR_W;

    t_edge             r_mem [DEPTH];
    t_edge             r_rdata;
    logic [ADDR_W-1:0] r_clr_addr;
    logic              r_clr_busy;

    // clearing sweep, one entry per cycle after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.wr) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

[hdl/dsm_core.sv]
module dsm_core
    import dsm_pkg::*;
#(
    parameter int STATE_COUNT   = STATE_COUNT_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
    parameter int ADDR_W        = tbl_state_bits(STATE_COUNT_DEF) + $clog2(ALPHABET_SIZE_DEF)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // item channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [OP_W-1:0]    i_op,
    input  logic [STATE_W-1:0] i_state_index,
    input  logic [SYM_W-1:0]   i_symbol,
    input  logic [STATE_W-1:0] i_next_state,
    input  logic               i_edge_valid,
    input  logic               i_terminal_flag,
    input  logic               i_last,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_accepted,
    output logic [CAUSE_W-1:0] o_reject_cause,
    // start state register
    input  logic               i_cfg_wr,
    input  logic [STATE_W-1:0] i_cfg_start,
    output logic [STATE_W-1:0] o_start_state,
    // transition table
    input  logic               i_clr_busy,
    output t_tbl_ctl           o_tbl_ctl,
    output logic [ADDR_W-1:0]  o_tbl_addr,
    output t_edge              o_tbl_wdata,
    input  t_edge              i_tbl_rdata
);

    localparam int SW         = tbl_state_bits(STATE_COUNT);
    localparam int AW         = ADDR_W - SW;
    localparam int TBL_STATES = 1 << SW;

    t_op                r_s1_op;
    logic               r_s1_valid;
    logic [SYM_W-1:0]   r_s1_sym;
    logic               r_s1_last;

    logic [STATE_W-1:0] r_start;
    logic [STATE_W-1:0] r_cur;
    logic               r_dead;
    logic               r_term [TBL_STATES];

    logic               r_out_valid;
    logic               r_out_acc;
    t_cause             r_out_cause;

    t_op                in_op;
    logic               in_acc;
    logic               s1_has_res;
    logic               s1_move;
    logic [STATE_W-1:0] n_cur;
    logic               n_dead;
    logic               res_acc;
    t_cause             res_cause;
    logic               edge_wr;

    assign in_op = t_op'(i_op);

    assign s1_has_res = r_s1_valid &&
                        ((r_s1_op == OP_FEED && r_s1_last) || r_s1_op == OP_EMPTY_Q);
    // stage 1 holds only when it carries a result and the output register is blocked
    assign s1_move    = !s1_has_res || !r_out_valid || !i_out_stall;
    assign o_in_stall = i_clr_busy || !s1_move;
    assign in_acc     = i_in_valid && !o_in_stall;

    // stage 1: resolve the table read for a fed symbol, and the verdict for a last symbol or an empty query
    always_comb begin
        logic [STATE_W-1:0] walk;
        logic               walk_dead;
        logic               term;
        walk      = r_cur;
        walk_dead = r_dead;
        term      = 1'b0;
        n_cur     = r_cur;
        n_dead    = r_dead;
        res_acc   = 1'b0;
        res_cause = CAUSE_NONE;
        if (r_s1_valid) begin
            case (r_s1_op)
                OP_FEED: begin
                    if (!r_dead) begin
                        if (state_ok(r_cur, STATE_COUNT) && sym_ok(r_s1_sym, ALPHABET_SIZE)
                            && i_tbl_rdata.ok) begin
                            walk = i_tbl_rdata.dest;
                        end else begin
                            walk_dead = 1'b1;
                        end
                    end
                    n_cur  = walk;
                    n_dead = walk_dead;
                    if (r_s1_last) begin
                        term = state_ok(walk, STATE_COUNT) && r_term[walk[SW-1:0]];
                        if (walk_dead) begin
                            res_cause = CAUSE_NO_EDGE;
                        end else begin
                            res_acc   = term;
                            res_cause = term ? CAUSE_NONE : CAUSE_NOT_TERM;
                        end
                        n_cur  = r_start;
                        n_dead = 1'b0;
                    end
                end
                OP_EMPTY_Q: begin
                    term      = state_ok(r_start, STATE_COUNT) && r_term[r_start[SW-1:0]];
                    res_acc   = term;
                    res_cause = term ? CAUSE_NONE : CAUSE_NOT_TERM;
                end
                default: begin
                end
            endcase
        end
    end

    // table access at the accept edge; the read address follows the state left by stage 1
    assign edge_wr = in_acc && in_op == OP_EDGE_WR &&
                     state_ok(i_state_index, STATE_COUNT) &&
                     state_ok(i_next_state, STATE_COUNT) &&
                     sym_ok(i_symbol, ALPHABET_SIZE);

    assign o_tbl_ctl.wr = edge_wr;
    assign o_tbl_ctl.rd = in_acc && in_op == OP_FEED;
    assign o_tbl_addr   = (in_op == OP_EDGE_WR)
                        ? {i_state_index[SW-1:0], i_symbol[AW-1:0]}
                        : {n_cur[SW-1:0], i_symbol[AW-1:0]};
    assign o_tbl_wdata.ok   = i_edge_valid;
    assign o_tbl_wdata.dest = i_edge_valid ? i_next_state : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_move) begin
            r_s1_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s1_op   <= in_op;
            r_s1_sym  <= i_symbol;
            r_s1_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_cur   <= '0;
            r_dead  <= 1'b0;
        end else if (i_cfg_wr) begin
            // a new start state aborts any string in progress
            r_start <= i_cfg_start;
            r_cur   <= i_cfg_start;
            r_dead  <= 1'b0;
        end else if (s1_move) begin
            r_cur   <= n_cur;
            r_dead  <= n_dead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TBL_STATES; i++) begin
                r_term[i] <= 1'b0;
            end
        end else if (in_acc && in_op == OP_TERM_WR && state_ok(i_state_index, STATE_COUNT)) begin
            r_term[i_state_index[SW-1:0]] <= i_terminal_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && s1_has_res) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && s1_has_res) begin
            r_out_acc   <= res_acc;
            r_out_cause <= res_cause;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out_acc;
    assign o_reject_cause = r_out_cause;
    assign o_start_state  = r_start;

endmodule

[hdl/dsm_checker.sv]
module dsm_checker
    import dsm_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic               o_accepted,
    input logic [CAUSE_W-1:0] o_reject_cause
);

    // the clearing sweep follows every reset
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("items taken right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_accepted) && $stable(o_reject_cause))
        else $error("stalled result changed");

    a_acc_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_accepted == (o_reject_cause == CAUSE_NONE)))
        else $error("accepted flag disagrees with reject cause");

    a_cause_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_reject_cause == CAUSE_NONE || o_reject_cause == CAUSE_NO_EDGE ||
                         o_reject_cause == CAUSE_NOT_TERM))
        else $error("reject cause out of range");

endmodule

bind dfa_string_matcher_top dsm_checker u_dsm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_accepted     (o_accepted),
    .o_reject_cause (o_reject_cause)
);

[sim/testbench.sv]
module testbench
    import dsm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // run shape
    localparam int N_PHASES     = 6;   // start-state settings after the directed part
    localparam int PHASE_ITEMS  = 250; // mixed traffic per phase, after the table fill
    localparam int SET_SIZE     = 4;   // bytes that carry most edges in one phase
    localparam int SETTLE_LAT   = 4;   // covers the two-stage pipe after the last result
    localparam int PRINT_CAP    = 100;
    localparam int HI_W         = APB_W - STATE_W;

    localparam logic [PADDR_W-1:0] START_ADDR = PADDR_W'(4 * REG_START_STATE);

    // one transaction on the item channel
    typedef struct packed {
        t_op                op;
        logic [STATE_W-1:0] st;
        logic [SYM_W-1:0]   sym;
        logic [STATE_W-1:0] nxt;
        logic               ev;
        logic               tf;
        logic               lst;
    } t_item;

    // one verdict on the result channel
    typedef struct packed {
        logic   accepted;
        t_cause cause;
    } t_verdict;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_LIGHT,
        STALL_HOLD
    } t_stall_mode;

    // ------------------------------------------------------------------
    // automaton model: mirrors the table, the flags and the walk, and
    // queues the verdict each string or empty query should produce
    // ------------------------------------------------------------------
    class verdict_model;
        t_edge              trans_tbl [STATE_COUNT_DEF][ALPHABET_SIZE_DEF];
        logic               accepting [STATE_COUNT_DEF];
        logic [STATE_W-1:0] start_st;
        logic [STATE_W-1:0] cur_st;
        bit                 dead;
        t_verdict           verdict_q [$];
        int                 fails;

        function new();
            foreach (trans_tbl[s, c]) trans_tbl[s][c] = '0;
            foreach (accepting[s]) accepting[s] = 1'b0;
            start_st = '0;
            cur_st   = '0;
            dead     = 0;
            fails    = 0;
        endfunction

        function bit is_accepting(logic [STATE_W-1:0] s);
            return int'(s) < STATE_COUNT_DEF && accepting[s] == 1'b1;
        endfunction

        // a new start state drops any string in progress
        function void take_start(logic [STATE_W-1:0] s);
            start_st = s;
            cur_st   = s;
            dead     = 0;
        endfunction

        function void note_item(t_item it);
            t_verdict v;
            case (it.op)
                OP_EDGE_WR: begin
                    if (int'(it.st) < STATE_COUNT_DEF && int'(it.sym) < ALPHABET_SIZE_DEF &&
                        int'(it.nxt) < STATE_COUNT_DEF) begin
                        trans_tbl[it.st][it.sym].ok   = it.ev;
                        trans_tbl[it.st][it.sym].dest = it.ev ? it.nxt : '0;
                    end
                end
                OP_TERM_WR: begin
                    if (int'(it.st) < STATE_COUNT_DEF) accepting[it.st] = it.tf;
                end
                OP_EMPTY_Q: begin
                    v.accepted = is_accepting(start_st);
                    v.cause    = v.accepted ? CAUSE_NONE : CAUSE_NOT_TERM;
                    verdict_q.push_back(v);
                end
                default: begin
                    if (!dead) begin
                        if (int'(cur_st) < STATE_COUNT_DEF && int'(it.sym) < ALPHABET_SIZE_DEF &&
                            trans_tbl[cur_st][it.sym].ok) begin
                            cur_st = trans_tbl[cur_st][it.sym].dest;
                        end else begin
                            dead = 1;
                        end
                    end
                    if (it.lst) begin
                        if (dead) begin
                            v.accepted = 1'b0;
                            v.cause    = CAUSE_NO_EDGE;
                        end else begin
                            v.accepted = is_accepting(cur_st);
                            v.cause    = v.accepted ? CAUSE_NONE : CAUSE_NOT_TERM;
                        end
                        verdict_q.push_back(v);
                        cur_st = start_st;
                        dead   = 0;
                    end
                end
            endcase
        endfunction

        task report(string msg);
            fails++;
            if (fails <= PRINT_CAP) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_verdict(logic acc, logic [CAUSE_W-1:0] cause);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                report($sformatf("result with nothing pending: accepted=%0b cause=%0d",
                                 acc, cause));
                return;
            end
            want = verdict_q[0];
            verdict_q.delete(0);
            if (acc !== want.accepted)
                report($sformatf("accepted=%0b, want %0b", acc, want.accepted));
            if (cause !== want.cause)
                report($sformatf("reject_cause=%0d, want %0d", cause, want.cause));
        endtask
    endclass

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               psel            = 1'b0;
    logic               penable         = 1'b0;
    logic               pwrite          = 1'b0;
    logic [PADDR_W-1:0] paddr           = '0;
    logic [APB_W-1:0]   pwdata          = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;
    logic               i_in_valid      = 1'b0;
    logic               o_in_stall;
    logic [OP_W-1:0]    i_op            = '0;
    logic [STATE_W-1:0] i_state_index   = '0;
    logic [SYM_W-1:0]   i_symbol        = '0;
    logic [STATE_W-1:0] i_next_state    = '0;
    logic               i_edge_valid    = 1'b0;
    logic               i_terminal_flag = 1'b0;
    logic               i_last          = 1'b0;
    logic               o_out_valid;
    logic               i_out_stall     = 1'b0;
    logic               o_accepted;
    logic [CAUSE_W-1:0] o_reject_cause;

    verdict_model sb = new();

    // byte set that most edges and fed symbols are drawn from in a phase
    logic [SYM_W-1:0] phase_syms [SET_SIZE];

    // sender burst state
    int burst_left = 0;

    // result-side stall pattern
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;

    always #1 i_clk = ~i_clk;

    dfa_string_matcher_top DUT (.*);

    // ------------------------------------------------------------------
    // receiver: stalls in segments of random length, each segment with
    // its own character (free run, coin flip, light, solid hold)
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(1, 48);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_COIN:  i_out_stall <= 1'($urandom_range(0, 1));
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            default:     i_out_stall <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // monitor: config writes and item transactions feed the model in the
    // order the block sees them, result transactions get checked
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_item seen;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr == START_ADDR)
                sb.take_start(pwdata[STATE_W-1:0]);
            if (i_in_valid && !o_in_stall) begin
                seen.op  = t_op'(i_op);
                seen.st  = i_state_index;
                seen.sym = i_symbol;
                seen.nxt = i_next_state;
                seen.ev  = i_edge_valid;
                seen.tf  = i_terminal_flag;
                seen.lst = i_last;
                sb.note_item(seen);
            end
            if (o_out_valid && !i_out_stall)
                sb.check_verdict(o_accepted, o_reject_cause);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_item rand_item();
        t_item it;
        it.op  = t_op'($urandom_range(0, 3));
        it.st  = STATE_W'($urandom);
        it.sym = SYM_W'($urandom);
        it.nxt = STATE_W'($urandom);
        it.ev  = 1'($urandom);
        it.tf  = 1'($urandom);
        it.lst = 1'($urandom);
        return it;
    endfunction

    function automatic t_item mk(t_op op, logic [STATE_W-1:0] st, logic [SYM_W-1:0] sym,
                                 logic [STATE_W-1:0] nxt, logic ev, logic tf, logic lst);
        t_item it;
        it.op  = op;
        it.st  = st;
        it.sym = sym;
        it.nxt = nxt;
        it.ev  = ev;
        it.tf  = tf;
        it.lst = lst;
        return it;
    endfunction

    // mostly bytes that have edges this phase, now and then any byte
    function automatic logic [SYM_W-1:0] pick_sym();
        if ($urandom_range(0, 99) < 93) return phase_syms[$urandom_range(0, SET_SIZE - 1)];
        return SYM_W'($urandom);
    endfunction

    // one transaction; valid drops only for the gap between bursts, and
    // the payload holds while the block stalls
    task automatic send(t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid      <= 1'b1;
        i_op            <= it.op;
        i_state_index   <= it.st;
        i_symbol        <= it.sym;
        i_next_state    <= it.nxt;
        i_edge_valid    <= it.ev;
        i_terminal_flag <= it.tf;
        i_last          <= it.lst;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // setup then access for a write, the same for a read-back of the value
    task automatic write_start_state(logic [STATE_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= START_ADDR;
        pwdata  <= {HI_W'($urandom), v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {{HI_W{1'b0}}, v})
            sb.report($sformatf("start_state reads 0x%0h, want 0x%0h", prdata, v));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // idle the item side until every verdict is in, then let the pipe empty;
    // the first edge lets the monitor log the last transaction
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.verdict_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_LAT) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_item it;
        int    n;
        int    len;
        int    sel;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part with the start state at zero; the block sweeps its
        // table after reset and stalls items meanwhile
        write_start_state('0);
        // empty string while the start state is not accepting
        send(mk(OP_EMPTY_Q, 4'hA, 8'h5A, 4'h5, 1'b1, 1'b1, 1'b1));
        // one-symbol string with no edge at all
        send(mk(OP_FEED, 4'h5, 8'h00, 4'hA, 1'b1, 1'b0, 1'b1));
        send(mk(OP_EDGE_WR, 4'h0, 8'hFF, 4'hF, 1'b1, 1'b0, 1'b1));
        send(mk(OP_TERM_WR, 4'hF, 8'h00, 4'h0, 1'b0, 1'b1, 1'b0));
        // accepted string
        send(mk(OP_FEED, 4'h0, 8'hFF, 4'h0, 1'b0, 1'b0, 1'b1));
        // dead on the first symbol, still dead on the last
        send(mk(OP_FEED, 4'hF, 8'h00, 4'hF, 1'b1, 1'b1, 1'b0));
        send(mk(OP_FEED, 4'h0, 8'hFF, 4'h0, 1'b0, 1'b0, 1'b1));
        send(mk(OP_EDGE_WR, 4'hF, 8'h00, 4'h0, 1'b1, 1'b1, 1'b0));
        // empty query in the middle of a string, string ends non-accepting
        send(mk(OP_FEED, 4'h3, 8'hFF, 4'hC, 1'b0, 1'b1, 1'b0));
        send(mk(OP_EMPTY_Q, 4'hF, 8'hFF, 4'hF, 1'b0, 1'b0, 1'b0));
        send(mk(OP_FEED, 4'hC, 8'h00, 4'h3, 1'b1, 1'b0, 1'b1));
        // start state accepting: empty string passes
        send(mk(OP_TERM_WR, 4'h0, 8'hFF, 4'hF, 1'b1, 1'b1, 1'b1));
        send(mk(OP_EMPTY_Q, 4'h0, 8'h00, 4'h0, 1'b1, 1'b0, 1'b0));
        // edge loaded mid-string is used by the next symbol
        send(mk(OP_FEED, 4'h0, 8'hFF, 4'h0, 1'b0, 1'b0, 1'b0));
        send(mk(OP_EDGE_WR, 4'hF, 8'h80, 4'hA, 1'b1, 1'b0, 1'b1));
        send(mk(OP_FEED, 4'h0, 8'h80, 4'h0, 1'b0, 1'b1, 1'b1));
        // removed edge reads as missing
        send(mk(OP_EDGE_WR, 4'h0, 8'hFF, 4'hF, 1'b0, 1'b1, 1'b0));
        send(mk(OP_FEED, 4'hF, 8'hFF, 4'hF, 1'b1, 1'b1, 1'b1));
        send(mk(OP_TERM_WR, 4'h0, 8'h55, 4'h5, 1'b0, 1'b0, 1'b0));
        send(mk(OP_EDGE_WR, 4'h0, 8'h55, 4'hF, 1'b1, 1'b1, 1'b0));
        // left open on purpose: the next start-state write abandons it
        send(mk(OP_FEED, 4'hA, 8'h55, 4'h5, 1'b1, 1'b0, 1'b0));
        wait_results_done();

        for (int p = 0; p < N_PHASES; p++) begin
            write_start_state(p == 0 ? 4'hF : p == 1 ? 4'h0 : STATE_W'($urandom));
            foreach (phase_syms[k]) phase_syms[k] = SYM_W'($urandom);
            if (p < 2) phase_syms[0] = (p == 0) ? 8'hFF : 8'h00;

            // dense table over this phase's bytes so strings walk deep
            for (int s = 0; s < STATE_COUNT_DEF; s++) begin
                foreach (phase_syms[k]) begin
                    it     = rand_item();
                    it.op  = OP_EDGE_WR;
                    it.st  = STATE_W'(s);
                    it.sym = phase_syms[k];
                    it.ev  = ($urandom_range(0, 99) < 85);
                    send(it);
                end
            end
            for (int s = 0; s < STATE_COUNT_DEF; s++) begin
                it    = rand_item();
                it.op = OP_TERM_WR;
                it.st = STATE_W'(s);
                send(it);
            end

            n = 0;
            while (n < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    // well-formed string, now and then a load or query inside
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 8);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 19) == 0) begin
                            it = rand_item();
                            if (it.op == OP_FEED) it.op = OP_EMPTY_Q;
                            send(it);
                            n++;
                        end
                        it     = rand_item();
                        it.op  = OP_FEED;
                        it.sym = pick_sym();
                        it.lst = (i == len - 1);
                        send(it);
                        n++;
                    end
                end else if (sel < 80) begin
                    it    = rand_item();
                    it.op = OP_EMPTY_Q;
                    send(it);
                    n++;
                end else if (sel < 90) begin
                    it    = rand_item();
                    it.op = $urandom_range(0, 1) ? OP_EDGE_WR : OP_TERM_WR;
                    if (it.op == OP_EDGE_WR) it.sym = pick_sym();
                    send(it);
                    n++;
                end else begin
                    // noise: any op, any fields, strings cut anywhere
                    send(rand_item());
                    n++;
                end
            end
            wait_results_done();
        end

        if (sb.verdict_q.size() != 0)
            sb.report($sformatf("%0d verdicts never arrived", sb.verdict_q.size()));
        if (sb.fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
